// ----- hdl/dsa_pkg.sv -----
// ----------------------------------------------------------------------------
// dsa_pkg
// Shared types, widths and codes of the descriptor slot allocator.
// ----------------------------------------------------------------------------
package dsa_pkg;

  localparam int MAX_DESCRIPTORS = 64;
  localparam int HEAP_SLOTS      = 64;

  localparam int ADDR_W   = 64;
  localparam int SIZE_W   = 13;
  localparam int CAP_W    = 7;
  localparam int IDX_W    = 6;
  localparam int PROD_W   = IDX_W + SIZE_W;
  localparam int CFG_IW   = 3;
  localparam int STK_CW   = $clog2(MAX_DESCRIPTORS + 1);
  localparam int STK_AW   = (MAX_DESCRIPTORS > 1) ? $clog2(MAX_DESCRIPTORS) : 1;
  localparam int DIV_CW   = $clog2(ADDR_W);

  localparam logic [SIZE_W-1:0] SLOT_SIZE_RST = SIZE_W'(32);
  localparam logic [CAP_W-1:0]  SLOT_CAP_RST  = CAP_W'(64);

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NOT_READY  = 3'd1,
    ST_EXHAUSTED  = 3'd2,
    ST_BELOW_BASE = 3'd3,
    ST_MISALIGNED = 3'd4,
    ST_BEYOND_CAP = 3'd5,
    ST_STACK_FULL = 3'd6
  } status_t;

  typedef enum logic [CFG_IW-1:0] {
    CFG_HEAP_READY = 3'd0,
    CFG_SLOT_SIZE  = 3'd1,
    CFG_SLOT_CAP   = 3'd2,
    CFG_CPU_BASE   = 3'd3,
    CFG_GPU_BASE   = 3'd4
  } cfg_reg_t;

  typedef enum logic {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_POP_WAIT,
    S_MUL,
    S_ADD,
    S_DIV,
    S_DONE
  } seq_state_t;

  typedef struct packed {
    logic push;
    logic pop;
  } stk_ctrl_t;

endpackage

// ----- hdl/dsa_channels.sv -----
// ----------------------------------------------------------------------------
// dsa channels
// Valid/ready channels for slot requests and slot responses.
// ----------------------------------------------------------------------------
interface dsa_req_if
  import dsa_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              kind;
  logic [ADDR_W-1:0] free_address;

  modport source (output valid, output kind, output free_address, input ready);
  modport sink   (input valid, input kind, input free_address, output ready);
endinterface

interface dsa_rsp_if
  import dsa_pkg::*;
;
  logic              valid;
  logic              ready;
  status_t           status;
  logic [ADDR_W-1:0] cpu_address;
  logic [ADDR_W-1:0] gpu_address;

  modport source (output valid, output status, output cpu_address, output gpu_address,
                  input ready);
  modport sink   (input valid, input status, input cpu_address, input gpu_address,
                  output ready);
endinterface

// ----- hdl/dsa_divider.sv -----
// ----------------------------------------------------------------------------
// dsa_divider
// Restoring divider, one quotient bit per cycle, 64-bit by 13-bit.
// ----------------------------------------------------------------------------
module dsa_divider
  import dsa_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [ADDR_W-1:0] dividend,
  input  logic [SIZE_W-1:0] divisor,
  output logic              done,
  output logic [ADDR_W-1:0] quotient,
  output logic [SIZE_W-1:0] remainder
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DIV_CW-1:0] cnt_r, cnt_nxt;
  logic [ADDR_W-1:0] quo_r, quo_nxt;
  logic [SIZE_W-1:0] rem_r, rem_nxt;
  logic [SIZE_W-1:0] dvs_r, dvs_nxt;
  logic [SIZE_W:0]   rem_sh;
  logic              ge;

  assign rem_sh = {rem_r, quo_r[ADDR_W-1]};
  assign ge     = (rem_sh >= {1'b0, dvs_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      quo_nxt = {quo_r[ADDR_W-2:0], ge};
      rem_nxt = ge ? SIZE_W'(rem_sh - {1'b0, dvs_r}) : rem_sh[SIZE_W-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CW'(ADDR_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

// ----- hdl/dsa_slot_stack.sv -----
// ----------------------------------------------------------------------------
// dsa_slot_stack
// LIFO of returned slot indices in a memory, with registered pop data.
// ----------------------------------------------------------------------------
module dsa_slot_stack
  import dsa_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  stk_ctrl_t        ctrl,
  input  logic [IDX_W-1:0] push_data,
  output logic [IDX_W-1:0] pop_data,
  output logic [STK_CW-1:0] count
);

  logic [IDX_W-1:0]  mem [MAX_DESCRIPTORS];
  logic [STK_CW-1:0] count_r, count_nxt;
  logic [STK_CW-1:0] top_idx;
  logic [IDX_W-1:0]  rd_r;

  assign top_idx = count_r - 1'b1;

  always_comb begin
    count_nxt = count_r;
    if (ctrl.push) begin
      count_nxt = count_r + 1'b1;
    end else if (ctrl.pop) begin
      count_nxt = top_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      mem[count_r[STK_AW-1:0]] <= push_data;
    end
    if (ctrl.pop) begin
      rd_r <= mem[top_idx[STK_AW-1:0]];
    end
  end

  assign pop_data = rd_r;
  assign count    = count_r;

endmodule

// ----- hdl/descriptor_slot_allocator.sv -----
// ----------------------------------------------------------------------------
// descriptor_slot_allocator
// Allocates and frees descriptor slots: free-index stack plus bump pointer.
// ----------------------------------------------------------------------------
// allocate: decode, multiply and add states from accept to response valid, plus a pop-wait
// state on reuse for the registered stack read; not ready, exhausted, below base: decode only
// free: decode, then a wait on the 64-step serial divider before response valid
// one request at a time; next request accepted the cycle after the response is taken
// synchronous active-low reset: stack empty, bump pointer zero, registers to defaults
// ----------------------------------------------------------------------------
module descriptor_slot_allocator
  import dsa_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [ADDR_W-1:0] cfg_wdata,
  dsa_req_if.sink           in_req,
  dsa_rsp_if.source         out_rsp
);

  logic              heap_ready_r;
  logic [SIZE_W-1:0] slot_size_r;
  logic [CAP_W-1:0]  slot_cap_r;
  logic [ADDR_W-1:0] cpu_base_r;
  logic [ADDR_W-1:0] gpu_base_r;

  seq_state_t        state_r, state_nxt;
  logic [CAP_W-1:0]  fresh_r, fresh_nxt;
  logic              kind_r;
  logic [ADDR_W-1:0] addr_r;
  logic [IDX_W-1:0]  idx_r;
  logic [PROD_W-1:0] prod_r;
  status_t           status_r;
  logic [ADDR_W-1:0] cpu_out_r;
  logic [ADDR_W-1:0] gpu_out_r;

  logic [CAP_W-1:0]  eff_cap;
  logic              not_ready;
  logic              stk_empty;
  logic              exhausted;
  logic              below_base;
  logic [ADDR_W-1:0] offset;
  logic              div_start;
  logic              div_done;
  logic [ADDR_W-1:0] div_quo;
  logic [SIZE_W-1:0] div_rem;
  logic              misaligned;
  logic              beyond_cap;
  logic              stk_full;
  stk_ctrl_t         stk_ctrl;
  logic [IDX_W-1:0]  pop_data;
  logic [STK_CW-1:0] stk_count;
  logic              in_fire;
  logic              out_fire;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_ready_r <= 1'b0;
      slot_size_r  <= SLOT_SIZE_RST;
      slot_cap_r   <= SLOT_CAP_RST;
      cpu_base_r   <= '0;
      gpu_base_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_HEAP_READY: heap_ready_r <= cfg_wdata[0];
        CFG_SLOT_SIZE:  slot_size_r  <= cfg_wdata[SIZE_W-1:0];
        CFG_SLOT_CAP:   slot_cap_r   <= cfg_wdata[CAP_W-1:0];
        CFG_CPU_BASE:   cpu_base_r   <= cfg_wdata;
        CFG_GPU_BASE:   gpu_base_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign eff_cap    = (slot_cap_r > CAP_W'(HEAP_SLOTS)) ? CAP_W'(HEAP_SLOTS) : slot_cap_r;
  assign not_ready  = !heap_ready_r || (slot_size_r == '0);
  assign stk_empty  = (stk_count == '0);
  assign exhausted  = (fresh_r >= eff_cap);
  assign below_base = (addr_r < cpu_base_r);
  assign offset     = addr_r - cpu_base_r;
  assign misaligned = (div_rem != '0);
  assign beyond_cap = (div_quo >= ADDR_W'(eff_cap));
  assign stk_full   = (stk_count >= STK_CW'(MAX_DESCRIPTORS));
  assign in_fire    = in_req.valid && in_req.ready;
  assign out_fire   = out_rsp.valid && out_rsp.ready;

  dsa_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (offset),
    .divisor   (slot_size_r),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  dsa_slot_stack u_stk (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (stk_ctrl),
    .push_data (div_quo[IDX_W-1:0]),
    .pop_data  (pop_data),
    .count     (stk_count)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        if (not_ready) begin
          state_nxt = S_DONE;
        end else if (kind_r == KIND_ALLOC) begin
          if (!stk_empty)     state_nxt = S_POP_WAIT;
          else if (exhausted) state_nxt = S_DONE;
          else                state_nxt = S_MUL;
        end else begin
          state_nxt = below_base ? S_DONE : S_DIV;
        end
      end
      S_POP_WAIT: state_nxt = S_MUL;
      S_MUL:      state_nxt = S_ADD;
      S_ADD:      state_nxt = S_DONE;
      S_DIV: begin
        if (div_done) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_fire) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_req.ready  = (state_r == S_IDLE);
    out_rsp.valid = (state_r == S_DONE);
    div_start     = 1'b0;
    stk_ctrl.push = 1'b0;
    stk_ctrl.pop  = 1'b0;
    fresh_nxt     = fresh_r;
    case (state_r)
      S_DECODE: begin
        if (!not_ready && kind_r == KIND_ALLOC) begin
          if (!stk_empty) begin
            stk_ctrl.pop = 1'b1;
          end else if (!exhausted) begin
            fresh_nxt = fresh_r + 1'b1;
          end
        end
        if (!not_ready && kind_r == KIND_FREE && !below_base) begin
          div_start = 1'b1;
        end
      end
      S_DIV: begin
        stk_ctrl.push = div_done && !misaligned && !beyond_cap && !stk_full;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fresh_r <= '0;
    end else begin
      state_r <= state_nxt;
      fresh_r <= fresh_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          kind_r <= in_req.kind;
          addr_r <= in_req.free_address;
        end
      end
      S_DECODE: begin
        idx_r     <= fresh_r[IDX_W-1:0];
        cpu_out_r <= '0;
        gpu_out_r <= '0;
        if (not_ready)                  status_r <= ST_NOT_READY;
        else if (kind_r == KIND_ALLOC)  status_r <= exhausted && stk_empty ? ST_EXHAUSTED : ST_OK;
        else                            status_r <= below_base ? ST_BELOW_BASE : ST_OK;
      end
      S_POP_WAIT: idx_r <= pop_data;
      S_MUL: prod_r <= PROD_W'(idx_r) * PROD_W'(slot_size_r);
      S_ADD: begin
        cpu_out_r <= cpu_base_r + ADDR_W'(prod_r);
        gpu_out_r <= gpu_base_r + ADDR_W'(prod_r);
      end
      S_DIV: begin
        if (div_done) begin
          if (misaligned)      status_r <= ST_MISALIGNED;
          else if (beyond_cap) status_r <= ST_BEYOND_CAP;
          else if (stk_full)   status_r <= ST_STACK_FULL;
          else                 status_r <= ST_OK;
        end
      end
      default: ;
    endcase
  end

  assign out_rsp.status      = status_r;
  assign out_rsp.cpu_address = cpu_out_r;
  assign out_rsp.gpu_address = gpu_out_r;

  // checks
  a_stk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stk_count <= STK_CW'(MAX_DESCRIPTORS))
    else $error("slot stack over capacity");

  a_fresh_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fresh_r <= CAP_W'(HEAP_SLOTS))
    else $error("bump pointer beyond heap");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_rsp.valid && in_req.ready))
    else $error("request taken while response pending");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_rsp.valid && (out_rsp.status != ST_OK || kind_r == KIND_FREE)
      |-> out_rsp.cpu_address == '0 && out_rsp.gpu_address == '0)
    else $error("address on a non-allocating response");

  a_push_only_free: assert property (@(posedge clk) disable iff (!rst_n)
    stk_ctrl.push |-> kind_r == KIND_FREE && !stk_full)
    else $error("push outside a valid free");

endmodule
